// ===== src/kerp_pkg.sv =====
// Shared types and constants for the key edge record and playback block.
package kerp_pkg;

   // Frame store geometry
   localparam int DEPTH  = 4096;
   localparam int ADDR_W = 12;
   localparam int CNT_W  = 13;

   // Key mask geometry
   localparam int KEYS   = 8;
   localparam int MASK_W = 8;

   localparam logic [MASK_W-1:0] LIVE_MASK = MASK_W'((1 << KEYS) - 1);
   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_REC_START  = 2'd1,
      ACT_REC_END    = 2'd2,
      ACT_PLAY_START = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_RECORD = 2'd1,
      MODE_PLAY   = 2'd2
   } mode_type;

   typedef struct packed {
      action_type        action;
      logic [MASK_W-1:0] key_mask;
      logic [CNT_W-1:0]  record_limit;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] pressed_mask;
      logic [MASK_W-1:0] rising_mask;
      logic [MASK_W-1:0] falling_mask;
      mode_type          mode;
      logic [CNT_W-1:0]  recorded_count;
   } rsp_type;

endpackage

// ===== src/kerp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kerp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/key_edge_record_playback.sv =====
// Top level of the key edge record and playback block.
//
// Each request transfer carries an action: a frame tick with a live key mask,
// start recording with a frame limit, end recording, or start playback. Each
// request yields exactly one response transfer with the held, rising and
// falling key masks, the mode after the request and the number of stored
// frames. Command requests repeat the masks of the last tick.
// A request passes through the request register, during which the frame store
// is read at the next playback position, then the response register.
// Throughput is one request per cycle while responses are accepted, set by
// the single write and single read port of the 4096 x 8 frame store.
// Reset clears the key masks, mode (normal), counts and play position; the
// frame store is not cleared and needs no clearing pass, since only entries
// written since the last recording start are ever played.
// When the receiver stalls, the response register holds, the request
// register holds its item, and req_ready drops until the response moves.
module key_edge_record_playback
   import kerp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [MASK_W-1:0] cur_ff, cur_in;
   logic [MASK_W-1:0] prev_ff, prev_in;
   mode_type          mode_ff, mode_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [CNT_W-1:0]  allowed_ff, allowed_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;

   logic              advance;
   logic              req_xfer;
   logic              wr_en;
   logic [MASK_W-1:0] live_keys;
   logic [MASK_W-1:0] rd_data;

   // Handshake: process the held request when the response slot frees up
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   assign live_keys = s1_req_ff.key_mask & LIVE_MASK;

   // Frame store: write while recording, read at the next play position
   kerp_ram #(
      .WIDTH (MASK_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (stored_ff[ADDR_W-1:0]),
      .wr_data (live_keys),
      .rd_en   (req_xfer),
      .rd_addr (pos_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Next state for the request being processed
   always_comb begin
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      mode_in    = mode_ff;
      stored_in  = stored_ff;
      allowed_in = allowed_ff;
      pos_in     = pos_ff;
      wr_en      = 1'b0;
      if (advance) begin
         case (s1_req_ff.action)
            ACT_TICK: begin
               prev_in = cur_ff;
               cur_in  = '0;
               case (mode_ff)
                  MODE_NORMAL, MODE_RECORD: begin
                     cur_in = live_keys;
                     if (mode_ff == MODE_RECORD && stored_ff < allowed_ff &&
                         stored_ff < DEPTH_CNT) begin
                        wr_en     = 1'b1;
                        stored_in = stored_ff + 1'b1;
                     end
                  end
                  MODE_PLAY: begin
                     if (pos_ff < stored_ff && pos_ff < DEPTH_CNT) begin
                        cur_in = rd_data;
                        pos_in = pos_ff + 1'b1;
                     end else begin
                        mode_in = MODE_NORMAL;
                     end
                  end
                  default: begin
                     cur_in = '0;
                  end
               endcase
            end
            ACT_REC_START: begin
               allowed_in = (s1_req_ff.record_limit > DEPTH_CNT) ? DEPTH_CNT
                                                                  : s1_req_ff.record_limit;
               stored_in  = '0;
               mode_in    = MODE_RECORD;
            end
            ACT_REC_END: begin
               mode_in = MODE_NORMAL;
            end
            ACT_PLAY_START: begin
               pos_in  = '0;
               mode_in = MODE_PLAY;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Build the response from the updated state
   always_comb begin
      rsp_in.pressed_mask   = cur_in;
      rsp_in.rising_mask    = cur_in & ~prev_in;
      rsp_in.falling_mask   = prev_in & ~cur_in;
      rsp_in.mode           = mode_in;
      rsp_in.recorded_count = stored_in;
   end

   // Control and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         mode_ff      <= MODE_NORMAL;
         stored_ff    <= '0;
         allowed_ff   <= '0;
         pos_ff       <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         cur_ff     <= cur_in;
         prev_ff    <= prev_in;
         mode_ff    <= mode_in;
         stored_ff  <= stored_in;
         allowed_ff <= allowed_in;
         pos_ff     <= pos_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
